// ===== hw/rtl/mbep_pkg.sv =====
// ============================================================================
// mbep_pkg: shared types and constants for the escape-time pixel engine
// Payload structs, register index codes and reset values of the config regs.
// ============================================================================
package mbep_pkg;

    // default fixed-point format: signed, 32 bits, 26 fraction bits
    localparam int COORD_BITS_DEF    = 32;
    localparam int FRACTION_BITS_DEF = 26;

    // payload widths
    localparam int POSITION_BITS = 10;
    localparam int COUNT_BITS    = 12;
    localparam int LIGHT_BITS    = 8;

    // coordinate queue between mapping front and iteration back
    localparam int QUEUE_DEPTH = 2;

    // config port
    localparam int CFG_IDX_BITS = 2;

    // config reset values
    localparam int MAX_ITER_RESET   = 128;
    localparam int LEFT_REAL_RESET  = -150994944;
    localparam int TOP_IMAG_RESET   = -75497472;
    localparam int PIXEL_STEP_RESET = 314573;

    // config register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MAX_ITER   = 2'd0,
        CFG_LEFT_REAL  = 2'd1,
        CFG_TOP_IMAG   = 2'd2,
        CFG_PIXEL_STEP = 2'd3
    } t_cfg_idx;

    // one pixel request
    typedef struct packed {
        logic [POSITION_BITS-1:0] column;
        logic [POSITION_BITS-1:0] row;
    } t_pixel;

    // one pixel result
    typedef struct packed {
        logic [COUNT_BITS-1:0] iteration_count;
        logic                  inside_set;
        logic [LIGHT_BITS-1:0] lightness;
    } t_result;

endpackage

// ===== hw/rtl/mbep_front.sv =====
// ============================================================================
// mbep_front: pixel to complex-plane mapping
// Registers the pixel, multiplies column and row by the step, then adds the
// origin with saturation and pushes the point c into the coordinate queue.
// ============================================================================
module mbep_front #(
    parameter int COORD_BITS    = mbep_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = mbep_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  mbep_pkg::t_pixel              i_pixel,
    input  logic signed [COORD_BITS-1:0]  i_left_real,
    input  logic signed [COORD_BITS-1:0]  i_top_imag,
    input  logic [FRACTION_BITS:0]        i_pixel_step,
    output logic                          o_busy,
    output logic                          o_push,
    output logic [2*COORD_BITS-1:0]       o_point
);

    localparam int STEP_W = FRACTION_BITS + 1;
    localparam int PROD_W = mbep_pkg::POSITION_BITS + STEP_W;
    localparam int SUM_W  = ((COORD_BITS > PROD_W) ? COORD_BITS : PROD_W) + 2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_ADD
    } t_fstate;

    t_fstate                           r_state;
    logic [mbep_pkg::POSITION_BITS-1:0] r_col;
    logic [mbep_pkg::POSITION_BITS-1:0] r_row;
    logic [PROD_W-1:0]                 r_prod_re;
    logic [PROD_W-1:0]                 r_prod_im;
    logic signed [SUM_W-1:0]           sum_re;
    logic signed [SUM_W-1:0]           sum_im;
    logic signed [COORD_BITS-1:0]      c_re;
    logic signed [COORD_BITS-1:0]      c_im;
    logic                              re_ok;
    logic                              im_ok;

    // sequencer: capture, multiply, add and push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_accept) begin
                        r_state <= F_MUL;
                    end
                end
                F_MUL:   r_state <= F_ADD;
                F_ADD:   r_state <= F_IDLE;
                default: r_state <= F_IDLE;
            endcase
        end
    end

    // pixel capture and offset products
    always_ff @(posedge i_clk) begin
        if (i_accept && (r_state == F_IDLE)) begin
            r_col <= i_pixel.column;
            r_row <= i_pixel.row;
        end
        if (r_state == F_MUL) begin
            r_prod_re <= PROD_W'(r_col) * PROD_W'(i_pixel_step);
            r_prod_im <= PROD_W'(r_row) * PROD_W'(i_pixel_step);
        end
    end

    // origin plus offset, saturated to the coordinate range
    always_comb begin
        sum_re = $signed({{(SUM_W-COORD_BITS){i_left_real[COORD_BITS-1]}}, i_left_real})
               + $signed({{(SUM_W-PROD_W){1'b0}}, r_prod_re});
        sum_im = $signed({{(SUM_W-COORD_BITS){i_top_imag[COORD_BITS-1]}}, i_top_imag})
               + $signed({{(SUM_W-PROD_W){1'b0}}, r_prod_im});
        re_ok  = (sum_re[SUM_W-1:COORD_BITS-1] == {(SUM_W-COORD_BITS+1){sum_re[SUM_W-1]}});
        im_ok  = (sum_im[SUM_W-1:COORD_BITS-1] == {(SUM_W-COORD_BITS+1){sum_im[SUM_W-1]}});
        if (re_ok) begin
            c_re = sum_re[COORD_BITS-1:0];
        end else if (sum_re[SUM_W-1]) begin
            c_re = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            c_re = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
        if (im_ok) begin
            c_im = sum_im[COORD_BITS-1:0];
        end else if (sum_im[SUM_W-1]) begin
            c_im = {1'b1, {(COORD_BITS-1){1'b0}}};
        end else begin
            c_im = {1'b0, {(COORD_BITS-1){1'b1}}};
        end
    end

    assign o_busy  = (r_state != F_IDLE);
    assign o_push  = (r_state == F_ADD);
    assign o_point = {c_re, c_im};

endmodule

// ===== hw/rtl/mbep_queue.sv =====
// ============================================================================
// mbep_queue: small point queue
// Holds mapped points between the front and the iteration engine so that
// the next pixel can be mapped while the current one iterates.
// ============================================================================
module mbep_queue #(
    parameter int WIDTH = 2 * mbep_pkg::COORD_BITS_DEF,
    parameter int DEPTH = mbep_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH-1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH-1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);

endmodule

// ===== hw/rtl/mbep_iter.sv =====
// ============================================================================
// mbep_iter: escape-time iteration engine
// Runs z = z*z + c on one shared set of multipliers (multiply, update),
// then derives lightness with a bit-serial divider.
// ============================================================================
module mbep_iter #(
    parameter int COORD_BITS    = mbep_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = mbep_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  logic [2*COORD_BITS-1:0]             i_point,
    input  logic [mbep_pkg::COUNT_BITS-1:0]     i_max_iter,
    output logic                                o_pop,
    output logic                                o_done,
    output mbep_pkg::t_result                   o_result
);

    localparam int W      = COORD_BITS;
    localparam int PW     = 2 * COORD_BITS;
    localparam int CW     = mbep_pkg::COUNT_BITS;
    localparam int LW     = mbep_pkg::LIGHT_BITS;
    localparam int REM_W  = CW + LW;
    localparam int BIT_W  = $clog2(LW);
    localparam int CMP_W  = (W + 1 > FRACTION_BITS + 3) ? W + 1 : FRACTION_BITS + 3;
    localparam logic [CMP_W-1:0] BOUND = CMP_W'(4) << FRACTION_BITS;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_UPD,
        B_DIV
    } t_bstate;

    t_bstate                 r_state;
    logic                    r_done;
    mbep_pkg::t_result       r_result;

    logic signed [W-1:0]     r_c_re;
    logic signed [W-1:0]     r_c_im;
    logic signed [W-1:0]     r_x;
    logic signed [W-1:0]     r_y;
    logic signed [PW-1:0]    r_p_xx;
    logic signed [PW-1:0]    r_p_yy;
    logic signed [PW-1:0]    r_p_xy;
    logic [CW-1:0]           r_count;
    logic                    r_inside;
    logic [REM_W-1:0]        r_rem;
    logic [LW-1:0]           r_quot;
    logic [BIT_W-1:0]        r_bit;

    logic signed [W-1:0]     x2;
    logic signed [W-1:0]     y2;
    logic signed [W-1:0]     two_xy;
    logic signed [W-1:0]     re_part;
    logic signed [W-1:0]     n_x;
    logic signed [W-1:0]     n_y;
    logic [W:0]              mag_sum;
    logic                    escaped;
    logic                    at_limit;
    logic                    stop;
    logic [CW-1:0]           diff;
    logic [REM_W-1:0]        trial;
    logic                    q_bit;

    // saturate a double-width value to the coordinate range
    function automatic logic signed [W-1:0] sat_wide(input logic signed [PW-1:0] v);
        logic ok;
        ok = (v[PW-1:W-1] == {(PW-W+1){v[PW-1]}});
        if (ok) begin
            return v[W-1:0];
        end else if (v[PW-1]) begin
            return {1'b1, {(W-1){1'b0}}};
        end else begin
            return {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    // saturate a one-bit-grown sum to the coordinate range
    function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] v);
        if (v[W] == v[W-1]) begin
            return v[W-1:0];
        end else if (v[W]) begin
            return {1'b1, {(W-1){1'b0}}};
        end else begin
            return {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    // squares, cross term, escape test and next z
    always_comb begin
        x2       = sat_wide(r_p_xx >>> FRACTION_BITS);
        y2       = sat_wide(r_p_yy >>> FRACTION_BITS);
        two_xy   = sat_wide(r_p_xy >>> (FRACTION_BITS - 1));
        mag_sum  = {1'b0, x2} + {1'b0, y2};
        escaped  = (CMP_W'(mag_sum) > BOUND);
        at_limit = (r_count >= i_max_iter);
        stop     = escaped || at_limit;
        re_part  = sat_sum({x2[W-1], x2} - {y2[W-1], y2});
        n_x      = sat_sum({re_part[W-1], re_part} + {r_c_re[W-1], r_c_re});
        n_y      = sat_sum({two_xy[W-1], two_xy} + {r_c_im[W-1], r_c_im});
        diff     = i_max_iter - r_count;
    end

    // restoring divide step, one quotient bit per cycle
    always_comb begin
        trial = REM_W'(i_max_iter) << r_bit;
        q_bit = (i_max_iter != '0) && (r_rem >= trial);
    end

    // sequencer with registered result and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                B_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= B_MUL;
                    end
                end
                B_MUL: r_state <= B_UPD;
                B_UPD: begin
                    r_state <= stop ? B_DIV : B_MUL;
                end
                B_DIV: begin
                    if (r_bit == '0) begin
                        r_state                  <= B_IDLE;
                        r_done                   <= 1'b1;
                        r_result.iteration_count <= r_count;
                        r_result.inside_set      <= r_inside;
                        r_result.lightness       <= {r_quot[LW-2:0], q_bit};
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // iteration and divider datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (i_q_valid) begin
                    r_c_re  <= i_point[PW-1:W];
                    r_c_im  <= i_point[W-1:0];
                    r_x     <= '0;
                    r_y     <= '0;
                    r_count <= '0;
                end
            end
            B_MUL: begin
                r_p_xx <= PW'(r_x) * PW'(r_x);
                r_p_yy <= PW'(r_y) * PW'(r_y);
                r_p_xy <= PW'(r_x) * PW'(r_y);
            end
            B_UPD: begin
                if (stop) begin
                    r_inside <= at_limit;
                    r_rem    <= (REM_W'(diff) << LW) - REM_W'(diff);
                    r_bit    <= BIT_W'(LW - 1);
                end else begin
                    r_x     <= n_x;
                    r_y     <= n_y;
                    r_count <= r_count + CW'(1);
                end
            end
            B_DIV: begin
                if (q_bit) begin
                    r_rem <= r_rem - trial;
                end
                r_quot <= {r_quot[LW-2:0], q_bit};
                r_bit  <= r_bit - BIT_W'(1);
            end
            default: begin
                r_count <= r_count;
            end
        endcase
    end

    assign o_pop    = (r_state == B_IDLE) && i_q_valid;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/mandelbrot_escape_time_pixel.sv =====
// ============================================================================
// mandelbrot_escape_time_pixel: escape-time evaluator for one pixel
// Maps a pixel to a point c, iterates z = z*z + c and reports the count,
// the inside flag and a lightness value.
// ============================================================================
//
//  channel   | handshake           | payload             | transfer when
//  ----------+---------------------+---------------------+-------------------
//  pixel in  | start / busy        | i_pixel (t_pixel)   | start && !busy
//  result    | o_done strobe       | o_result (t_result) | o_done high
//  config    | i_cfg_we            | i_cfg_idx, data     | i_cfg_we high
//
//  per pixel the back end pops a point, then passes n+1 times, n = iterations
//  performed, through the loop of the shared multipliers and the product
//  register, then runs the bit-serial lightness divider.
//  mapping of the next pixel (capture, multiply, add) overlaps the current
//  iteration and a two-entry point queue lets two mapped pixels wait.
//  reset is synchronous and active low; config comes out of reset with
//  its default view. results cannot be held off by the receiver.
//
module mandelbrot_escape_time_pixel #(
    parameter int COORD_BITS    = mbep_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = mbep_pkg::FRACTION_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  mbep_pkg::t_pixel                       i_pixel,
    output logic                                   o_done,
    output mbep_pkg::t_result                      o_result,
    input  logic                                   i_cfg_we,
    input  logic [mbep_pkg::CFG_IDX_BITS-1:0]      i_cfg_idx,
    input  logic [((COORD_BITS > FRACTION_BITS + 1) ?
                   COORD_BITS : FRACTION_BITS + 1)-1:0] i_cfg_data
);

    localparam int STEP_W = FRACTION_BITS + 1;
    localparam int CW     = mbep_pkg::COUNT_BITS;

    logic [CW-1:0]                 r_max_iter;
    logic signed [COORD_BITS-1:0]  r_left_real;
    logic signed [COORD_BITS-1:0]  r_top_imag;
    logic [STEP_W-1:0]             r_pixel_step;

    logic                          accept;
    logic                          front_busy;
    logic                          push;
    logic [2*COORD_BITS-1:0]       point_in;
    logic [2*COORD_BITS-1:0]       point_out;
    logic                          q_full;
    logic                          q_valid;
    logic                          pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iter   <= CW'(mbep_pkg::MAX_ITER_RESET);
            r_left_real  <= COORD_BITS'(mbep_pkg::LEFT_REAL_RESET);
            r_top_imag   <= COORD_BITS'(mbep_pkg::TOP_IMAG_RESET);
            r_pixel_step <= STEP_W'(mbep_pkg::PIXEL_STEP_RESET);
        end else if (i_cfg_we) begin
            case (mbep_pkg::t_cfg_idx'(i_cfg_idx))
                mbep_pkg::CFG_MAX_ITER:   r_max_iter   <= i_cfg_data[CW-1:0];
                mbep_pkg::CFG_LEFT_REAL:  r_left_real  <= i_cfg_data[COORD_BITS-1:0];
                mbep_pkg::CFG_TOP_IMAG:   r_top_imag   <= i_cfg_data[COORD_BITS-1:0];
                mbep_pkg::CFG_PIXEL_STEP: r_pixel_step <= i_cfg_data[STEP_W-1:0];
                default:                  r_max_iter   <= r_max_iter;
            endcase
        end
    end

    // pixel transfer: front idle and room in the queue for its point
    assign busy   = front_busy || q_full;
    assign accept = start && !busy;

    mbep_front #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_pixel      (i_pixel),
        .i_left_real  (r_left_real),
        .i_top_imag   (r_top_imag),
        .i_pixel_step (r_pixel_step),
        .o_busy       (front_busy),
        .o_push       (push),
        .o_point      (point_in)
    );

    mbep_queue #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (mbep_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (point_in),
        .i_pop     (pop),
        .o_rd_data (point_out),
        .o_full    (q_full),
        .o_valid   (q_valid)
    );

    mbep_iter #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_iter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_point    (point_out),
        .i_max_iter (r_max_iter),
        .o_pop      (pop),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

// ===== hw/rtl/mbep_checker.sv =====
// ============================================================================
// mbep_checker: port-level checks for the escape-time pixel engine
// Watches pixel transfers and result strobes; attached by bind.
// ============================================================================
module mbep_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic              o_done,
    input  mbep_pkg::t_result o_result
);

    // a result strobe is never followed directly by another
    a_done_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("back-to-back result strobes");

    // a pixel transfer occupies the mapping front for the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("not busy after pixel transfer");

    // inside points are black
    a_inside_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.inside_set) |-> (o_result.lightness == '0))
        else $error("inside point with nonzero lightness");

    // an escaped point took at least one iteration
    a_escape_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.inside_set) |-> (o_result.iteration_count != '0))
        else $error("escape reported with zero iterations");

endmodule

bind mandelbrot_escape_time_pixel mbep_checker u_mbep_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the escape-time pixel engine
// Feeds pixel requests through the start/busy port under several views of
// the complex plane, predicts each escape count, inside flag and lightness
// in fixed point, and checks every result strobe against the prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mbep_pkg::*;

    localparam int     COORD_BITS    = COORD_BITS_DEF;
    localparam int     FRAC_BITS     = FRACTION_BITS_DEF;
    localparam int     CFG_DATA_BITS = (COORD_BITS > FRAC_BITS + 1) ? COORD_BITS : FRAC_BITS + 1;
    localparam longint COORD_MAX     = (longint'(1) << (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN     = -COORD_MAX - 1;
    localparam longint ESCAPE_BOUND  = longint'(4) << FRAC_BITS;

    typedef enum int {VIEW_PLANE, VIEW_NOISE, VIEW_DEEP} t_view_kind;

    // clock, reset and block inputs, known from time zero
    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     start      = 1'b0;
    t_pixel                   i_pixel    = '0;
    logic                     i_cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     busy;
    logic                     o_done;
    t_result                  o_result;

    // bench copy of the view registers
    logic [COUNT_BITS-1:0]       iter_limit  = COUNT_BITS'(MAX_ITER_RESET);
    logic signed [COORD_BITS-1:0] origin_re  = COORD_BITS'(LEFT_REAL_RESET);
    logic signed [COORD_BITS-1:0] origin_im  = COORD_BITS'(TOP_IMAG_RESET);
    logic [FRAC_BITS:0]          pixel_pitch = (FRAC_BITS + 1)'(PIXEL_STEP_RESET);

    t_pixel  pixels_to_send[$];
    t_result predicted_results[$];
    int      error_count = 0;
    int      burst_left  = 1;
    int      gap_left    = 0;

    mandelbrot_escape_time_pixel #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pixel    (i_pixel),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // saturate to the signed coordinate range
    function automatic longint clamp_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    // exact product floored to the fixed-point grid, then saturated
    function automatic longint fixed_product(longint a, longint b, int shift);
        return clamp_coord((a * b) >>> shift);
    endfunction

    // escape count, inside flag and lightness of one pixel under the current view
    function automatic t_result escape_time(t_pixel px);
        longint  c_re, c_im, zr, zi, zr_sq, zi_sq, twice_rzi;
        int      count, limit;
        t_result r;
        c_re  = clamp_coord(longint'(origin_re) + longint'(px.column) * longint'(pixel_pitch));
        c_im  = clamp_coord(longint'(origin_im) + longint'(px.row) * longint'(pixel_pitch));
        zr    = 0;
        zi    = 0;
        zr_sq = 0;
        zi_sq = 0;
        count = 0;
        limit = int'(iter_limit);
        while (zr_sq + zi_sq <= ESCAPE_BOUND && count < limit) begin
            twice_rzi = fixed_product(zr, zi, FRAC_BITS - 1);
            zi        = clamp_coord(twice_rzi + c_im);
            zr        = clamp_coord(clamp_coord(zr_sq - zi_sq) + c_re);
            zr_sq     = fixed_product(zr, zr, FRAC_BITS);
            zi_sq     = fixed_product(zi, zi, FRAC_BITS);
            count++;
        end
        r.iteration_count = count[COUNT_BITS-1:0];
        r.inside_set      = (count >= limit);
        r.lightness       = (limit == 0) ? '0 : LIGHT_BITS'((255 * (limit - count)) / limit);
        return r;
    endfunction

    // pixel driver: bursts with random gaps, holds start while busy
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start      <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (start && !busy) begin
                predicted_results.push_back(escape_time(i_pixel));
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start   <= 1'b0;
                    i_pixel <= t_pixel'($urandom);
                end else if (pixels_to_send.size() != 0) begin
                    start   <= 1'b1;
                    i_pixel <= pixels_to_send.pop_front();
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    start   <= 1'b0;
                    i_pixel <= t_pixel'($urandom);
                end
            end
        end
    end

    // result checker: each strobe against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_done) begin
            if (predicted_results.size() == 0) begin
                $error("result transfer with nothing predicted: %p", o_result);
                error_count++;
            end else begin
                want = predicted_results.pop_front();
                if (o_result.iteration_count !== want.iteration_count) begin
                    $error("iteration_count: expected %0d, got %0d",
                           want.iteration_count, o_result.iteration_count);
                    error_count++;
                end
                if (o_result.inside_set !== want.inside_set) begin
                    $error("inside_set: expected %0b, got %0b",
                           want.inside_set, o_result.inside_set);
                    error_count++;
                end
                if (o_result.lightness !== want.lightness) begin
                    $error("lightness: expected %0d, got %0d",
                           want.lightness, o_result.lightness);
                    error_count++;
                end
            end
        end
    end

    // register write, mirrored into the bench copy
    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_MAX_ITER:   iter_limit  = value[COUNT_BITS-1:0];
            CFG_LEFT_REAL:  origin_re   = value[COORD_BITS-1:0];
            CFG_TOP_IMAG:   origin_im   = value[COORD_BITS-1:0];
            CFG_PIXEL_STEP: pixel_pitch = value[FRAC_BITS:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // hold off until every queued pixel is sent and every result is back
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixels_to_send.size() != 0 || start || predicted_results.size() != 0);
    endtask

    task automatic send_pixel(int col, int row);
        t_pixel px;
        px.column = col[POSITION_BITS-1:0];
        px.row    = row[POSITION_BITS-1:0];
        pixels_to_send.push_back(px);
    endtask

    // random view of the plane: around the set, pure noise, or a deep limit
    task automatic program_view(t_view_kind kind);
        int limit, left, top, pitch;
        if (kind == VIEW_NOISE) begin
            write_reg(CFG_MAX_ITER, CFG_DATA_BITS'($urandom_range(0, 511)));
            write_reg(CFG_LEFT_REAL, CFG_DATA_BITS'($urandom));
            write_reg(CFG_TOP_IMAG, CFG_DATA_BITS'($urandom));
            write_reg(CFG_PIXEL_STEP, CFG_DATA_BITS'($urandom));
        end else begin
            if (kind == VIEW_DEEP) limit = (1 << COUNT_BITS) - 1;
            else if ($urandom_range(0, 3) == 0) limit = $urandom_range(65, 300);
            else limit = $urandom_range(1, 64);
            // real part in [-2.5, 0.5], imaginary part in [-1.5, 1.5]
            left  = int'($urandom_range(0, 3 << FRAC_BITS)) - (5 << (FRAC_BITS - 1));
            top   = int'($urandom_range(0, 3 << FRAC_BITS)) - (3 << (FRAC_BITS - 1));
            pitch = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2000)
                                                : $urandom_range(20000, 400000);
            write_reg(CFG_MAX_ITER, CFG_DATA_BITS'(limit));
            write_reg(CFG_LEFT_REAL, CFG_DATA_BITS'(left));
            write_reg(CFG_TOP_IMAG, CFG_DATA_BITS'(top));
            write_reg(CFG_PIXEL_STEP, CFG_DATA_BITS'(pitch));
        end
    endtask

    // stimulus: directed views first, then random views of the plane
    initial begin
        t_view_kind kind;
        int         items;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default view: corners, the origin and a point in the period-2 bulb
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(0, 1023);
        send_pixel(1023, 0);
        send_pixel(480, 240);
        send_pixel(300, 240);
        wait_idle();

        // zero limit: no iteration at all
        write_reg(CFG_MAX_ITER, '0);
        send_pixel(100, 100);
        send_pixel(1023, 0);
        wait_idle();

        // extreme registers: mapped point saturates, the only iteration reaches the limit
        write_reg(CFG_MAX_ITER, 1);
        write_reg(CFG_LEFT_REAL, CFG_DATA_BITS'(COORD_MIN));
        write_reg(CFG_TOP_IMAG, CFG_DATA_BITS'(COORD_MAX));
        write_reg(CFG_PIXEL_STEP, CFG_DATA_BITS'(1 << FRAC_BITS));
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(1023, 0);
        wait_idle();

        // zero step at full limit: c = -2 sits on the escape bound, then c = 0
        write_reg(CFG_MAX_ITER, CFG_DATA_BITS'((1 << COUNT_BITS) - 1));
        write_reg(CFG_LEFT_REAL, CFG_DATA_BITS'(-(2 << FRAC_BITS)));
        write_reg(CFG_TOP_IMAG, '0);
        write_reg(CFG_PIXEL_STEP, '0);
        send_pixel(1023, 1023);
        wait_idle();
        write_reg(CFG_LEFT_REAL, '0);
        send_pixel(0, 0);
        wait_idle();

        // cusp at 0.25: slow creep toward the boundary
        write_reg(CFG_MAX_ITER, 2048);
        write_reg(CFG_LEFT_REAL, CFG_DATA_BITS'(1 << (FRAC_BITS - 2)));
        write_reg(CFG_PIXEL_STEP, 1);
        send_pixel(0, 0);
        send_pixel(1023, 0);
        wait_idle();

        // fine grid near the neck of the cardioid
        write_reg(CFG_MAX_ITER, 200);
        write_reg(CFG_LEFT_REAL, CFG_DATA_BITS'(-(3 << (FRAC_BITS - 2))));
        write_reg(CFG_TOP_IMAG, CFG_DATA_BITS'((1 << FRAC_BITS) / 10));
        write_reg(CFG_PIXEL_STEP, 64);
        repeat (4) send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));

        // random views, each programmed once the engine has drained
        for (int phase = 0; phase < 22; phase++) begin
            if (phase == 7 || phase == 15) kind = VIEW_DEEP;
            else if (phase % 5 == 4) kind = VIEW_NOISE;
            else kind = VIEW_PLANE;
            items = (kind == VIEW_DEEP) ? 6 : 50;
            wait_idle();
            program_view(kind);
            repeat (items) send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #16_000_000;
        $display("testbench: errors");
        $finish;
    end

endmodule
